>>> hw/rtl/bsp_pkg.sv
// Package for the bit stream packer: request/response payloads, command codes,
// and the controller-to-datapath command and status structs.
// No dependencies.
package bsp_pkg;

   localparam int MAX_NUMBER_BYTES_DEF = 8;

   // Request command codes
   localparam logic [1:0] CMD_BIT   = 2'd0;
   localparam logic [1:0] CMD_BYTE  = 2'd1;
   localparam logic [1:0] CMD_NUM   = 2'd2;
   localparam logic [1:0] CMD_CLOSE = 2'd3;

   typedef struct packed {
      logic [1:0]  cmd;
      logic        bit_value;
      logic [7:0]  byte_value;
      logic [63:0] number_value;
      logic [3:0]  number_bytes;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_header;
      logic       last;
   } rsp_type;

   // Datapath operations issued by the controller
   typedef enum logic [2:0] {
      OP_IDLE,
      OP_BIT,
      OP_BYTE,
      OP_NUM_LOAD,
      OP_NUM_NEXT,
      OP_CLOSE,
      OP_HDR
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      out_load;
      logic      out_last;
   } dp_ctrl_type;

   typedef struct packed {
      logic out_free;
      logic cnt_zero;
      logic cnt_seven;
      logic nb_zero;
      logic nb_one;
      logic rem_one;
   } dp_stat_type;

endpackage

>>> hw/rtl/bsp_datapath.sv
// Datapath of the bit stream packer: pending bits, number shift register,
// pad count and the response register.
// Depends on bsp_pkg.
module bsp_datapath import bsp_pkg::*; #(
   parameter int MAX_NUMBER_BYTES = MAX_NUMBER_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_data,
   input  dp_ctrl_type ctrl,
   output dp_stat_type stat,
   input  logic        rsp_ready,
   output logic        rsp_valid,
   output rsp_type     rsp_data
);

   localparam int NUM_W = 8 * MAX_NUMBER_BYTES;
   localparam int RW    = $clog2(MAX_NUMBER_BYTES + 1);

   logic [6:0]       pend_bits_ff, pend_bits_in;
   logic [2:0]       pend_cnt_ff, pend_cnt_in;
   logic [2:0]       pad_ff, pad_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [RW-1:0]    rem_ff, rem_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic [RW-1:0]    nb_sat;
   logic [NUM_W-1:0] num_aligned;
   logic [7:0]       app_val;
   logic [14:0]      app_word;
   logic [7:0]       app_out;
   logic [6:0]       keep_mask;
   logic [6:0]       app_pend;
   logic [7:0]       bit_acc;
   logic [2:0]       pad_val;
   logic [7:0]       byte_rev;

   // Reverse a byte so that its LSB is appended first
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         byte_rev[i] = req_data.byte_value[7-i];
      end
   end

   // Saturate the byte width and left-align the number field
   always_comb begin
      if (req_data.number_bytes > 4'(MAX_NUMBER_BYTES)) begin
         nb_sat = RW'(MAX_NUMBER_BYTES);
      end else begin
         nb_sat = RW'(req_data.number_bytes);
      end
      num_aligned = req_data.number_value[NUM_W-1:0]
                    << {RW'(MAX_NUMBER_BYTES) - nb_sat, 3'b000};
   end

   // Append eight bits MSB-first behind the pending bits
   always_comb begin
      case (ctrl.op)
         OP_BYTE:     app_val = byte_rev;
         OP_NUM_LOAD: app_val = num_aligned[NUM_W-1 -: 8];
         OP_NUM_NEXT: app_val = num_ff[NUM_W-1 -: 8];
         default:     app_val = 8'd0;
      endcase
      app_word  = {pend_bits_ff, app_val};
      app_out   = 8'(app_word >> pend_cnt_ff);
      keep_mask = 7'((8'd1 << pend_cnt_ff) - 8'd1);
      app_pend  = app_val[6:0] & keep_mask;
      bit_acc   = {pend_bits_ff, req_data.bit_value};
      pad_val   = 3'(4'd8 - {1'b0, pend_cnt_ff});
   end

   // Next state of pending bits, number register and response
   always_comb begin
      pend_bits_in = pend_bits_ff;
      pend_cnt_in  = pend_cnt_ff;
      pad_in       = pad_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      rsp_in       = rsp_ff;
      rsp_in.out_byte  = 8'd0;
      rsp_in.is_header = 1'b0;
      rsp_in.last      = ctrl.out_last;
      case (ctrl.op)
         OP_BIT: begin
            rsp_in.out_byte = bit_acc;
            if (pend_cnt_ff == 3'd7) begin
               pend_bits_in = 7'd0;
               pend_cnt_in  = 3'd0;
            end else begin
               pend_bits_in = bit_acc[6:0];
               pend_cnt_in  = pend_cnt_ff + 3'd1;
            end
         end
         OP_BYTE: begin
            if (pend_cnt_ff == 3'd0) begin
               rsp_in.out_byte = req_data.byte_value;
            end else begin
               rsp_in.out_byte = app_out;
               pend_bits_in    = app_pend;
            end
         end
         OP_NUM_LOAD: begin
            rsp_in.out_byte = app_out;
            pend_bits_in    = app_pend;
            num_in          = num_aligned << 8;
            rem_in          = nb_sat - RW'(1);
         end
         OP_NUM_NEXT: begin
            rsp_in.out_byte = app_out;
            pend_bits_in    = app_pend;
            num_in          = num_ff << 8;
            rem_in          = rem_ff - RW'(1);
         end
         OP_CLOSE: begin
            if (pend_cnt_ff == 3'd0) begin
               rsp_in.is_header = 1'b1;
            end else begin
               rsp_in.out_byte = 8'({1'b0, pend_bits_ff} << pad_val);
               pad_in          = pad_val;
            end
            pend_bits_in = 7'd0;
            pend_cnt_in  = 3'd0;
         end
         OP_HDR: begin
            rsp_in.out_byte  = {5'd0, pad_ff};
            rsp_in.is_header = 1'b1;
         end
         default: begin
         end
      endcase
      if (ctrl.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Hold control state under reset, payload without
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_bits_ff <= 7'd0;
         pend_cnt_ff  <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_bits_ff <= pend_bits_in;
         pend_cnt_ff  <= pend_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pad_ff <= pad_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      if (ctrl.out_load) begin
         rsp_ff <= rsp_in;
      end
   end

   // Report status to the controller
   always_comb begin
      stat.out_free  = !rsp_valid_ff || rsp_ready;
      stat.cnt_zero  = (pend_cnt_ff == 3'd0);
      stat.cnt_seven = (pend_cnt_ff == 3'd7);
      stat.nb_zero   = (nb_sat == RW'(0));
      stat.nb_one    = (nb_sat == RW'(1));
      stat.rem_one   = (rem_ff == RW'(1));
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> hw/rtl/bsp_ctrl.sv
// Controller of the bit stream packer: takes requests and sequences the
// datapath through multi-byte numbers and the close header.
// Depends on bsp_pkg.
module bsp_ctrl import bsp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic [1:0]  req_cmd,
   output logic        req_ready,
   input  dp_stat_type stat,
   output dp_ctrl_type ctrl
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_NUM,
      ST_HDR
   } state_type;

   state_type state_ff, state_in;

   // Decode the next operation and state
   always_comb begin
      state_in      = state_ff;
      req_ready     = 1'b0;
      ctrl.op       = OP_IDLE;
      ctrl.out_load = 1'b0;
      ctrl.out_last = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = stat.out_free;
            if (req_valid && stat.out_free) begin
               case (req_cmd)
                  CMD_BIT: begin
                     ctrl.op       = OP_BIT;
                     ctrl.out_load = stat.cnt_seven;
                     ctrl.out_last = 1'b1;
                  end
                  CMD_BYTE: begin
                     ctrl.op       = OP_BYTE;
                     ctrl.out_load = 1'b1;
                     ctrl.out_last = 1'b1;
                  end
                  CMD_NUM: begin
                     if (!stat.nb_zero) begin
                        ctrl.op       = OP_NUM_LOAD;
                        ctrl.out_load = 1'b1;
                        ctrl.out_last = stat.nb_one;
                        if (!stat.nb_one) begin
                           state_in = ST_NUM;
                        end
                     end
                  end
                  CMD_CLOSE: begin
                     ctrl.op       = OP_CLOSE;
                     ctrl.out_load = 1'b1;
                     ctrl.out_last = stat.cnt_zero;
                     if (!stat.cnt_zero) begin
                        state_in = ST_HDR;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_NUM: begin
            if (stat.out_free) begin
               ctrl.op       = OP_NUM_NEXT;
               ctrl.out_load = 1'b1;
               ctrl.out_last = stat.rem_one;
               if (stat.rem_one) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_HDR: begin
            if (stat.out_free) begin
               ctrl.op       = OP_HDR;
               ctrl.out_load = 1'b1;
               ctrl.out_last = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hw/rtl/bit_stream_packer_core.sv
// Channel  Handshake              Payload
// req      req_valid / req_ready  req_data  (req_type: cmd, bit, byte, number, width)
// rsp      rsp_valid / rsp_ready  rsp_data  (rsp_type: out_byte, is_header, last)
//
// A multi-byte number steps through the number state and a close with pending bits
// adds a header from the header state, one response a cycle unless stalled, out of
// the single response register. A new request is taken once the controller is idle
// and the response register is empty or being drained. Reset is synchronous and
// clears the pending bits and the response valid; a stalled response holds.
// Top level of the bit stream packer. Depends on bsp_pkg, bsp_ctrl, bsp_datapath.
module bit_stream_packer_core import bsp_pkg::*; #(
   parameter int MAX_NUMBER_BYTES = MAX_NUMBER_BYTES_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   dp_ctrl_type ctrl;
   dp_stat_type stat;

   // Sequence requests
   bsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_data.cmd),
      .req_ready (req_ready),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   // Pack bits and drive responses
   bsp_datapath #(
      .MAX_NUMBER_BYTES (MAX_NUMBER_BYTES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .ctrl      (ctrl),
      .stat      (stat),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

>>> hw/rtl/bsp_checker.sv
// Port-level checks for the bit stream packer, bound to the top level.
// Depends on bsp_pkg and bit_stream_packer_core.
module bsp_checker import bsp_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // A header carries a pad count below eight
   a_hdr_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_header |-> rsp_data.out_byte[7:3] == 5'd0)
      else $error("header pad count out of range");

   // A header always ends its request
   a_hdr_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_header |-> rsp_data.last)
      else $error("header without last");

   // Take a request only while the response register can move
   a_req_room: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !rsp_valid || rsp_ready)
      else $error("request taken behind a stalled response");

   // Drop the response valid after reset
   a_rst_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind bit_stream_packer_core bsp_checker u_bsp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
